// ----- sv/ppht_pkg.sv -----
// ---------------------------------------------------------------------------
// ppht_pkg : shared types and constants for the path point hit tester
// Holds coordinate widths, outcode bits, controller states and the
// command/status structs between controller and datapath.
// ---------------------------------------------------------------------------
package ppht_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int WIDTH_BITS     = 23;

    localparam logic [3:0] OC_LEFT   = 4'h1;
    localparam logic [3:0] OC_RIGHT  = 4'h2;
    localparam logic [3:0] OC_BELOW  = 4'h4;
    localparam logic [3:0] OC_ABOVE  = 4'h8;

    localparam logic KIND_STRIP = 1'b0;
    localparam logic KIND_FAN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VERT,
        ST_EDGE,
        ST_CLOSE,
        ST_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, update element setup
        logic vert;      // vertex/segment or fan edge test on prev -> cur
        logic close;     // closing fan edge cur -> start
        logic commit;    // update prev/start/count after vertex
        logic clear;     // clear per-element accumulators after result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic last;
        logic fan_close; // closing edge test needed
    } sts_t;

endpackage

// ----- sv/ppht_datapath.sv -----
// ---------------------------------------------------------------------------
// ppht_datapath : geometry datapath of the hit tester
// Latches one vertex, computes outcode, vertex distance, segment distance
// and fan crossing over registered product stages.
// ---------------------------------------------------------------------------
module ppht_datapath #(
    parameter int COORD_BITS = ppht_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic signed [COORD_BITS-1:0]  query_x,
    input  logic signed [COORD_BITS-1:0]  query_y,
    input  logic signed [COORD_BITS-1:0]  in_x,
    input  logic signed [COORD_BITS-1:0]  in_y,
    input  logic                          in_kind,
    input  logic [ppht_pkg::WIDTH_BITS-1:0] in_width,
    input  logic                          in_first,
    input  logic                          in_last,
    input  ppht_pkg::cmd_t                cmd,
    output ppht_pkg::sts_t                sts,
    output logic                          res_hit,
    output logic                          res_skipped
);
    import ppht_pkg::*;

    localparam int DB = COORD_BITS + 1;     // difference width
    localparam int PB = 2 * DB;             // product width
    localparam int SB = PB + 1;             // sum of two products
    localparam int WB = WIDTH_BITS;
    // width of the squared cross product and of the width-length product
    localparam int QB = (2 * PB > PB + 2 * WB) ? 2 * PB : PB + 2 * WB;

    logic signed [COORD_BITS-1:0] cur_x_reg, cur_y_reg, start_x_reg, start_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;
    logic [3:0] prev_oc_reg, cur_oc_reg;
    logic [1:0] seen_reg;
    logic       parity_reg, hit_reg, kind_reg, last_reg;
    logic [WB-1:0] width_reg;

    // stage registers for products
    logic signed [SB-1:0] len2_reg, dot_reg, cross_reg, d2_reg;
    logic signed [PB-1:0] el_lhs_reg, el_rhs_reg;
    logic                 el_span_reg, el_dypos_reg;
    logic [2*WB-1:0]      w2_reg;
    logic                 oc_pass_reg, seg_ok_reg;
    logic [QB-1:0]        c2_reg, rhs_reg;
    logic                 stage_b_reg, stage_c_reg, stage_d_reg, close_reg;

    // partial products of the wide squares
    logic [PB-1:0]        pc_hh_reg, pc_hl_reg, pc_ll_reg;
    logic [DB+WB-1:0]     pr_hh_reg, pr_hl_reg, pr_lh_reg, pr_ll_reg;
    logic [PB-1:0]        cmag, lmag;
    logic [DB-1:0]        c_hi, c_lo, l_hi, l_lo;
    logic [WB-1:0]        w_hi, w_lo;

    // edge source/target for the fan test
    logic signed [COORD_BITS-1:0] e0x, e0y, e1x, e1y;
    logic signed [DB-1:0] vx, vy, rx, ry, dxq, dyq;
    logic signed [DB:0] wneg, wpos;
    logic [3:0] oc;

    always_comb begin
        e0x = cmd.close ? cur_x_reg : prev_x_reg;
        e0y = cmd.close ? cur_y_reg : prev_y_reg;
        e1x = cmd.close ? start_x_reg : cur_x_reg;
        e1y = cmd.close ? start_y_reg : cur_y_reg;
        vx  = DB'(e1x) - DB'(e0x);
        vy  = DB'(e1y) - DB'(e0y);
        rx  = DB'(query_x) - DB'(e0x);
        ry  = DB'(query_y) - DB'(e0y);
        dxq = DB'(in_x) - DB'(query_x);
        dyq = DB'(in_y) - DB'(query_y);
    end

    // outcode of the incoming vertex against the box of the half-width
    logic [WB-1:0] w_eff;
    assign w_eff = in_first ? in_width : width_reg;
    always_comb begin
        wpos = (DB+1)'(w_eff);
        wneg = -wpos;
        oc = 4'h0;
        if ((DB+1)'(dxq) < wneg) oc |= OC_LEFT;
        if ((DB+1)'(dxq) > wpos) oc |= OC_RIGHT;
        if ((DB+1)'(dyq) < wneg) oc |= OC_BELOW;
        if ((DB+1)'(dyq) > wpos) oc |= OC_ABOVE;
    end

    // split magnitudes into halves for the narrow multipliers
    always_comb begin
        cmag = cross_reg[SB-1] ? PB'(-cross_reg) : PB'(cross_reg);
        lmag = PB'(len2_reg);
        c_hi = cmag[PB-1:DB];
        c_lo = cmag[DB-1:0];
        l_hi = lmag[PB-1:DB];
        l_lo = lmag[DB-1:0];
        w_hi = w2_reg[2*WB-1:WB];
        w_lo = w2_reg[WB-1:0];
    end

    // load item and element setup
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_x_reg  <= in_x;
            cur_y_reg  <= in_y;
            cur_oc_reg <= oc;
            last_reg   <= in_last;
            d2_reg     <= SB'(dxq * dxq) + SB'(dyq * dyq);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= '0; parity_reg <= 1'b0; hit_reg <= 1'b0;
            kind_reg <= KIND_STRIP; width_reg <= '0;
            prev_x_reg <= '0; prev_y_reg <= '0; prev_oc_reg <= '0;
            start_x_reg <= '0; start_y_reg <= '0;
            stage_b_reg <= 1'b0; stage_c_reg <= 1'b0; stage_d_reg <= 1'b0;
            close_reg <= 1'b0;
        end else begin
            if (cmd.load && in_first) begin
                seen_reg <= '0; parity_reg <= 1'b0; hit_reg <= 1'b0;
                kind_reg <= in_kind; width_reg <= in_width;
            end
            // stage A: products of the segment / edge
            stage_b_reg <= cmd.vert || cmd.close;
            close_reg   <= cmd.close;
            if (cmd.vert || cmd.close) begin
                len2_reg     <= SB'(vx * vx) + SB'(vy * vy);
                dot_reg      <= SB'(vx * rx) + SB'(vy * ry);
                cross_reg    <= SB'(vx * ry) - SB'(vy * rx);
                el_lhs_reg   <= vx * ry;
                el_rhs_reg   <= rx * vy;
                el_span_reg  <= (e1y < query_y) != (e0y < query_y);
                el_dypos_reg <= vy > 0;
                w2_reg       <= width_reg * width_reg;
                oc_pass_reg  <= (cur_oc_reg & prev_oc_reg) == 4'h0;
                // vertex test (strip) folds in here
                if (cmd.vert && kind_reg == KIND_STRIP && cur_oc_reg == 4'h0 &&
                    d2_reg <= SB'(width_reg * width_reg))
                    hit_reg <= 1'b1;
            end
            // stage B: partial products of squared cross and width times length
            stage_c_reg <= stage_b_reg && !close_reg && kind_reg == KIND_STRIP
                           && seen_reg != 2'd0;
            if (stage_b_reg) begin
                pc_hh_reg <= c_hi * c_hi;
                pc_hl_reg <= c_hi * c_lo;
                pc_ll_reg <= c_lo * c_lo;
                pr_hh_reg <= l_hi * w_hi;
                pr_hl_reg <= l_hi * w_lo;
                pr_lh_reg <= l_lo * w_hi;
                pr_ll_reg <= l_lo * w_lo;
                seg_ok_reg <= oc_pass_reg && len2_reg != '0 && dot_reg > 0 &&
                              dot_reg < len2_reg;
                if (kind_reg == KIND_FAN && (close_reg || seen_reg != 2'd0) &&
                    el_span_reg &&
                    (el_dypos_reg ? el_lhs_reg < el_rhs_reg : el_rhs_reg < el_lhs_reg))
                    parity_reg <= !parity_reg;
            end
            // stage C: sum the partial products
            stage_d_reg <= stage_c_reg && seg_ok_reg;
            if (stage_c_reg) begin
                c2_reg  <= QB'({pc_hh_reg, pc_ll_reg}) + (QB'(pc_hl_reg) << (DB + 1));
                rhs_reg <= QB'({pr_hh_reg, pr_ll_reg}) + (QB'(pr_hl_reg) << DB)
                           + (QB'(pr_lh_reg) << WB);
            end
            // stage D: segment compare
            if (stage_d_reg && c2_reg < rhs_reg)
                hit_reg <= 1'b1;
            if (cmd.commit) begin
                if (seen_reg == 2'd0) begin
                    start_x_reg <= cur_x_reg; start_y_reg <= cur_y_reg;
                end
                prev_x_reg <= cur_x_reg; prev_y_reg <= cur_y_reg;
                prev_oc_reg <= cur_oc_reg;
                if (seen_reg != 2'd3) seen_reg <= seen_reg + 2'd1;
            end
            if (cmd.clear) begin
                seen_reg <= '0; parity_reg <= 1'b0; hit_reg <= 1'b0;
            end
        end
    end

    // result (valid when controller sits in its result state)
    always_comb begin
        if (kind_reg == KIND_STRIP) begin
            res_skipped = seen_reg < 2'd2 || width_reg == '0;
            res_hit     = !res_skipped && hit_reg;
        end else begin
            res_skipped = seen_reg < 2'd3;
            res_hit     = !res_skipped && parity_reg;
        end
    end

    // closing edge when the fan reaches three vertices with this one
    assign sts.last      = last_reg;
    assign sts.fan_close = kind_reg == KIND_FAN && seen_reg >= 2'd2;

endmodule

// ----- sv/ppht_ctrl.sv -----
// ---------------------------------------------------------------------------
// ppht_ctrl : sequencer of the hit tester
// Steps one vertex through load, product stages, commit and result.
// ---------------------------------------------------------------------------
module ppht_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           res_load,
    input  logic           res_free,
    output ppht_pkg::cmd_t cmd,
    input  ppht_pkg::sts_t sts
);
    import ppht_pkg::*;

    state_t state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE; cnt_reg <= '0;
        end else begin
            state_reg <= state_next; cnt_reg <= cnt_next;
        end
    end

    // next state: ST_EDGE waits for the product stages to drain before the commit
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_VERT;
            ST_VERT: begin
                state_next = ST_EDGE; cnt_next = 2'd0;
            end
            ST_EDGE: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    if (!sts.last)          state_next = ST_IDLE;
                    else if (sts.fan_close) state_next = ST_CLOSE;
                    else                    state_next = ST_RESULT;
                    cnt_next = 2'd0;
                end
            end
            ST_CLOSE: begin
                cnt_next = cnt_reg + 2'd1;
                if (cnt_reg == 2'd2) begin
                    state_next = ST_RESULT; cnt_next = 2'd0;
                end
            end
            ST_RESULT: if (res_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd = '0;
        in_ready = 1'b0;
        res_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:   begin in_ready = 1'b1; cmd.load = in_valid; end
            ST_VERT:   cmd.vert = 1'b1;
            ST_EDGE:   cmd.commit = cnt_reg == 2'd2;
            ST_CLOSE:  cmd.close = cnt_reg == 2'd0;
            ST_RESULT: begin res_load = res_free; cmd.clear = res_free; end
            default:   ;
        endcase
    end

endmodule

// ----- sv/path_point_hit_tester_top.sv -----
// ---------------------------------------------------------------------------
// path_point_hit_tester_top : point hit test against strokes and fans
// Tests the configured query point against elements fed vertex by vertex.
//
// Usage:
//   s_axis carries one vertex per item; m_axis carries one result per
//   element, on its last vertex. The query point is written through
//   cfg_we/cfg_addr/cfg_wdata (0 = query_x, 1 = query_y) while idle.
//   Each vertex passes through load, product stage, partial-product stage,
//   sum stage, and compare with commit before the next vertex can be
//   taken. A last vertex then moves the result into the output register
//   in the result state once that register is free; a fan of three or
//   more vertices runs its closing edge before that. The result appears
//   the cycle after the move.
//   The output register holds one result; the next element's vertices are
//   still taken while it waits, and only the next result waits for
//   m_axis_tready.
//   Reset (aresetn low, synchronous) clears the query point, the element
//   state and the output valid flag.
// ---------------------------------------------------------------------------
module path_point_hit_tester_top #(
    parameter int COORD_BITS = ppht_pkg::COORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [COORD_BITS-1:0] cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: vertex_x, vertex_y, line_width (from bit 0 up)
    input  logic [((2*COORD_BITS+ppht_pkg::WIDTH_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: element_kind, first_vertex
    input  logic [1:0]  s_axis_tuser,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: hit, skipped (from bit 0 up)
    output logic [7:0]  m_axis_tdata
);
    import ppht_pkg::*;

    localparam logic REG_QX = 1'b0;
    localparam logic REG_QY = 1'b1;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    cmd_t cmd;
    sts_t sts;
    logic res_load, res_hit, res_skipped;
    logic out_valid_reg;
    logic [1:0] out_data_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg <= '0; qy_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_QX: qx_reg <= cfg_wdata;
                REG_QY: qy_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ppht_ctrl u_ctrl (
        .aclk, .aresetn,
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .res_load (res_load),
        .res_free (!out_valid_reg || m_axis_tready),
        .cmd, .sts
    );

    ppht_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .aclk, .aresetn,
        .query_x  (qx_reg),
        .query_y  (qy_reg),
        .in_x     (s_axis_tdata[COORD_BITS-1:0]),
        .in_y     (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .in_kind  (s_axis_tuser[0]),
        .in_width (s_axis_tdata[2*COORD_BITS+WIDTH_BITS-1:2*COORD_BITS]),
        .in_first (s_axis_tuser[1]),
        .in_last  (s_axis_tlast),
        .cmd, .sts,
        .res_hit, .res_skipped
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_load) begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {res_skipped, res_hit};
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_data_reg};

    // a result is only loaded when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwrote a pending item");
    // skipped results never report a hit
    a_skip_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !(res_hit && res_skipped))
        else $error("skipped element reported a hit");
    // no item taken while a vertex is in work
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item accepted during vertex work");

endmodule
